### sv/tcw_pkg.sv
// Package for the text console character writer.
// Holds the word types, op codes, control characters and cell layout.
// No dependencies.
package tcw_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned CURSOR_W = 11;
  localparam int unsigned CELL_W   = ATTR_W + CHAR_W;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd15;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CHAR_W-1:0]   read_char;
    logic [ATTR_W-1:0]   read_attr;
    logic                did_scroll;
  } out_word_t;

endpackage

### sv/tcw_screen_ram.sv
// Screen cell store: one write port and one read port with registered data.
// Uses tcw_pkg for the cell type.
module tcw_screen_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  tcw_pkg::cell_t wdata,
  input  logic           rd_en,
  input  logic [AW-1:0]  raddr,
  output tcw_pkg::cell_t rdata
);
  import tcw_pkg::*;

  cell_t mem [DEPTH];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/text_console_char_writer.sv
// Top level of the text console character writer.
// Uses tcw_pkg and tcw_screen_ram.
//
// Text console engine: a row-major screen of COLUMNS x ROWS cells (attribute
// byte high, character byte low) and a cursor. Each accepted word passes
// through S_EXEC and then S_RESP, which loads the result register; a tab
// adds S_TAB, which blanks cells up to the next tab stop or the line end (up
// to TAB_STOP cells), a clear adds S_FILL, which blanks every cell, and a put
// that scrolls adds S_PRIME and the S_SHIFT copy sweep, one cell per cycle
// through the screen memory's read port and write port. After reset a
// clearing pass over all COLUMNS*ROWS cells holds in_ready low; cfg writes are
// taken at any time. A new word is taken while a result waits on out_word.
module text_console_char_writer #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  tcw_pkg::in_word_t        in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tcw_pkg::out_word_t       out_word,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data
);
  import tcw_pkg::*;

  localparam int unsigned CELLS    = COLUMNS * ROWS;
  localparam int unsigned AW       = $clog2(CELLS);
  localparam int unsigned CW       = $clog2(CELLS + 1);
  localparam int unsigned COLW     = $clog2(COLUMNS);
  localparam int unsigned ROWW     = $clog2(ROWS + 1);
  localparam int unsigned TABW     = $clog2(TAB_STOP);
  localparam int unsigned TAB_LAST = (COLUMNS - 1) % TAB_STOP;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_TAB   = 3'd2;
  localparam logic [2:0] S_PRIME = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     cur_r, cur_nxt;
  logic [COLW-1:0]   col_r, col_nxt;
  logic [ROWW-1:0]   row_r, row_nxt;
  logic [TABW-1:0]   tab_r, tab_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic              scr_r, scr_nxt;
  logic              rst_fill_r, rst_fill_nxt;
  logic [ATTR_W-1:0] fill_attr_r, fill_attr_nxt;
  logic [ATTR_W-1:0] attr_r, attr_nxt;
  in_word_t          item_r, item_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  cell_t             wdata;
  logic              rd_en;
  logic [AW-1:0]     raddr;
  cell_t             rdata;

  logic              wrap;
  logic [CW-1:0]     adv_cur;
  logic [COLW-1:0]   adv_col;
  logic [ROWW-1:0]   adv_row;
  logic [TABW-1:0]   adv_tab;
  logic [AW:0]       ptr_ahead;
  logic              rd_in_range;
  cell_t             blank;

  tcw_screen_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .rd_en(rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign blank       = {attr_r, CH_SPACE};
  assign wrap        = (col_r == COLW'(COLUMNS - 1));
  assign adv_cur     = cur_r + CW'(1);
  assign adv_col     = wrap ? '0 : col_r + COLW'(1);
  assign adv_row     = wrap ? row_r + ROWW'(1) : row_r;
  assign adv_tab     = (wrap || tab_r == TABW'(TAB_STOP - 1)) ? '0 : tab_r + TABW'(1);
  assign ptr_ahead   = {1'b0, ptr_r} + (AW + 1)'(COLUMNS + 1);
  assign rd_in_range = (32'(item_r.read_index) < CELLS);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    tab_nxt       = tab_r;
    ptr_nxt       = ptr_r;
    scr_nxt       = scr_r;
    rst_fill_nxt  = rst_fill_r;
    fill_attr_nxt = fill_attr_r;
    attr_nxt      = attr_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    we            = 1'b0;
    waddr         = cur_r[AW-1:0];
    wdata         = blank;
    rd_en         = 1'b0;
    raddr         = AW'(item_r.read_index);

    if (cfg_valid) begin
      attr_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_word;
          scr_nxt   = 1'b0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_RESP;
        if (item_r.op == OP_PUT) begin
          priority if (item_r.char_code == CH_NEWLINE) begin
            cur_nxt = cur_r - CW'(col_r) + CW'(COLUMNS);
            col_nxt = '0;
            row_nxt = row_r + ROWW'(1);
            tab_nxt = '0;
            if (row_r == ROWW'(ROWS - 1)) begin
              state_nxt = S_PRIME;
            end
          end else if (item_r.char_code == CH_RETURN) begin
            cur_nxt = cur_r - CW'(col_r);
            col_nxt = '0;
            tab_nxt = '0;
          end else if (item_r.char_code == CH_BACKSPACE) begin
            if (cur_r != '0) begin
              cur_nxt = cur_r - CW'(1);
              we      = 1'b1;
              waddr   = cur_nxt[AW-1:0];
              if (col_r == '0) begin
                col_nxt = COLW'(COLUMNS - 1);
                row_nxt = row_r - ROWW'(1);
                tab_nxt = TABW'(TAB_LAST);
              end else begin
                col_nxt = col_r - COLW'(1);
                tab_nxt = (tab_r == '0) ? TABW'(TAB_STOP - 1) : tab_r - TABW'(1);
              end
            end
          end else if (item_r.char_code == CH_TAB) begin
            state_nxt = S_TAB;
          end else begin
            we      = 1'b1;
            wdata   = {attr_r, item_r.char_code};
            cur_nxt = adv_cur;
            col_nxt = adv_col;
            row_nxt = adv_row;
            tab_nxt = adv_tab;
            if (adv_row == ROWW'(ROWS)) begin
              state_nxt = S_PRIME;
            end
          end
        end else if (item_r.op == OP_READ) begin
          rd_en = rd_in_range;
        end else if (item_r.op == OP_CLEAR) begin
          ptr_nxt       = '0;
          fill_attr_nxt = attr_r;
          state_nxt     = S_FILL;
        end
      end

      S_TAB: begin
        we      = 1'b1;
        cur_nxt = adv_cur;
        col_nxt = adv_col;
        row_nxt = adv_row;
        tab_nxt = adv_tab;
        if (wrap || adv_tab == '0) begin
          state_nxt = (adv_row == ROWW'(ROWS)) ? S_PRIME : S_RESP;
        end
      end

      S_PRIME: begin
        rd_en     = 1'b1;
        raddr     = AW'(COLUMNS);
        ptr_nxt   = '0;
        state_nxt = S_SHIFT;
      end

      S_SHIFT: begin
        we    = 1'b1;
        waddr = ptr_r;
        wdata = (32'(ptr_r) < CELLS - COLUMNS) ? rdata : blank;
        rd_en = (32'(ptr_ahead) < CELLS);
        raddr = ptr_ahead[AW-1:0];
        ptr_nxt = ptr_r + AW'(1);
        if (32'(ptr_r) == CELLS - 1) begin
          cur_nxt   = cur_r - CW'(COLUMNS);
          row_nxt   = ROWW'(ROWS - 1);
          scr_nxt   = 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_FILL: begin
        we      = 1'b1;
        waddr   = ptr_r;
        wdata   = {fill_attr_r, CH_SPACE};
        ptr_nxt = ptr_r + AW'(1);
        if (32'(ptr_r) == CELLS - 1) begin
          rst_fill_nxt = 1'b0;
          state_nxt    = rst_fill_r ? S_IDLE : S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.cursor_pos = CURSOR_W'(cur_r);
          out_word_nxt.did_scroll = scr_r;
          if (item_r.op == OP_READ && rd_in_range) begin
            out_word_nxt.read_char = rdata[CHAR_W-1:0];
            out_word_nxt.read_attr = rdata[CELL_W-1:CHAR_W];
          end else begin
            out_word_nxt.read_char = '0;
            out_word_nxt.read_attr = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      cur_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      tab_r       <= '0;
      ptr_r       <= '0;
      scr_r       <= 1'b0;
      rst_fill_r  <= 1'b1;
      fill_attr_r <= RESET_ATTR;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      tab_r       <= tab_nxt;
      ptr_r       <= ptr_nxt;
      scr_r       <= scr_nxt;
      rst_fill_r  <= rst_fill_nxt;
      fill_attr_r <= fill_attr_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule
